>>> hdl/dgcd_pkg.sv
package dgcd_pkg;

	localparam int MAX_NODES_DEF = 64;

	localparam int CMD_W        = 2;
	localparam int NODE_W       = 6;
	localparam int NODE_COUNT_W = 7;

	localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} adj_ctl_t;

endpackage

>>> hdl/dgcd_adj_mem.sv
module dgcd_adj_mem #(
	parameter int MAX_NODES = dgcd_pkg::MAX_NODES_DEF,
	parameter int NW        = $clog2(MAX_NODES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dgcd_pkg::adj_ctl_t   ctl,
	input  logic [NW-1:0]        addr,
	input  logic [NW-1:0]        wr_col,
	output logic [MAX_NODES-1:0] row
);
	import dgcd_pkg::*;

	logic [MAX_NODES-1:0] mem [MAX_NODES];
	logic [MAX_NODES-1:0] row_vld_q;
	logic [MAX_NODES-1:0] row_q;
	logic                 rv_q;
	logic [MAX_NODES-1:0] col_bit;

	assign row     = rv_q ? row_q : '0;
	assign col_bit = {{(MAX_NODES-1){1'b0}}, 1'b1} << wr_col;

	// read-modify-write: a write follows a read of the same row
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			row_q <= mem[addr];
		end
		if (ctl.wr) begin
			mem[addr] <= row | col_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rv_q      <= 1'b0;
		end else begin
			if (ctl.rd) begin
				rv_q <= row_vld_q[addr];
			end
			if (ctl.clr) begin
				row_vld_q <= '0;
			end else if (ctl.wr) begin
				row_vld_q[addr] <= 1'b1;
			end
		end
	end

endmodule

>>> hdl/dgcd_stack.sv
module dgcd_stack #(
	parameter int MAX_NODES = dgcd_pkg::MAX_NODES_DEF,
	parameter int NW        = $clog2(MAX_NODES),
	parameter int CW        = $clog2(MAX_NODES + 1)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [NW-1:0] waddr,
	input  logic [NW-1:0] wnode,
	input  logic [CW-1:0] wcol,
	input  logic          re,
	input  logic [NW-1:0] raddr,
	output logic [NW-1:0] rnode,
	output logic [CW-1:0] rcol
);

	logic [NW+CW-1:0] mem [MAX_NODES];
	logic [NW+CW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wnode, wcol};
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rnode = rd_q[NW+CW-1:CW];
	assign rcol  = rd_q[CW-1:0];

endmodule

>>> hdl/dgcd_ctrl.sv
module dgcd_ctrl #(
	parameter int MAX_NODES = dgcd_pkg::MAX_NODES_DEF,
	parameter int NW        = $clog2(MAX_NODES),
	parameter int CW        = $clog2(MAX_NODES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dgcd_pkg::CMD_W-1:0]        cmd,
	input  logic [dgcd_pkg::NODE_W-1:0]       edge_from,
	input  logic [dgcd_pkg::NODE_W-1:0]       edge_to,
	input  logic [dgcd_pkg::NODE_COUNT_W-1:0] node_count,
	output dgcd_pkg::adj_ctl_t                adj_ctl,
	output logic [NW-1:0]                     adj_addr,
	output logic [NW-1:0]                     adj_wr_col,
	input  logic [MAX_NODES-1:0]              row,
	output logic                              stk_we,
	output logic [NW-1:0]                     stk_waddr,
	output logic [NW-1:0]                     stk_wnode,
	output logic [CW-1:0]                     stk_wcol,
	output logic                              stk_re,
	output logic [NW-1:0]                     stk_raddr,
	input  logic [NW-1:0]                     stk_rnode,
	input  logic [CW-1:0]                     stk_rcol,
	input  logic                              out_free,
	output logic                              fin_valid,
	output logic                              fin_res
);
	import dgcd_pkg::*;

	localparam int CMPW = (CW > NODE_COUNT_W) ? CW : NODE_COUNT_W;
	localparam logic [CMPW-1:0] MAXN_C = CMPW'(MAX_NODES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_POP  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]           state_q;
	logic [NW-1:0]        from_q;
	logic [NW-1:0]        to_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        root_q;
	logic [NW-1:0]        cur_q;
	logic [CW-1:0]        col_q;
	logic [CW-1:0]        depth_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] on_path_q;
	logic                 res_q;

	logic            accept;
	logic            edge_ok;
	logic [CMPW-1:0] nc_ext;
	logic [CW-1:0]   n_eff;
	logic [NW-1:0]   col_idx;
	logic [NW-1:0]   root_idx;
	logic            col_end;
	logic            root_end;
	logic            bit_hit;
	logic            scan_push;
	logic            scan_pop;
	logic            root_push;
	logic [CW-1:0]   depth_m1;
	logic [CW-1:0]   depth_m2;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign edge_ok   = (CMPW'(edge_from) < MAXN_C) && (CMPW'(edge_to) < MAXN_C);
	assign nc_ext    = CMPW'(node_count);
	assign n_eff     = (nc_ext > MAXN_C) ? CW'(MAXN_C) : CW'(nc_ext);
	assign col_idx   = col_q[NW-1:0];
	assign root_idx  = root_q[NW-1:0];
	assign col_end   = (col_q >= n_q);
	assign root_end  = (root_q >= n_q);
	assign bit_hit   = row[col_idx];
	assign scan_push = (state_q == ST_SCAN) && !col_end && bit_hit && !visited_q[col_idx];
	assign scan_pop  = (state_q == ST_SCAN) && col_end;
	assign root_push = (state_q == ST_ROOT) && !root_end && !visited_q[root_idx];
	assign depth_m1  = depth_q - CW'(1);
	assign depth_m2  = depth_q - CW'(2);

	assign fin_valid = (state_q == ST_DONE);
	assign fin_res   = res_q;

	always_comb begin
		adj_ctl.rd  = 1'b0;
		adj_ctl.wr  = 1'b0;
		adj_ctl.clr = accept && (cmd == CMD_CLEAR);
		adj_addr    = cur_q;
		adj_wr_col  = to_q;
		if (accept && (cmd == CMD_ADD) && edge_ok) begin
			adj_ctl.rd = 1'b1;
			adj_addr   = NW'(edge_from);
		end else if (state_q == ST_ADD) begin
			adj_ctl.wr = 1'b1;
			adj_addr   = from_q;
		end else if (root_push) begin
			adj_ctl.rd = 1'b1;
			adj_addr   = root_idx;
		end else if (scan_push) begin
			adj_ctl.rd = 1'b1;
			adj_addr   = col_idx;
		end else if (state_q == ST_POP) begin
			adj_ctl.rd = 1'b1;
			adj_addr   = stk_rnode;
		end
	end

	// the top of stack lives in cur_q/col_q; the memory holds the levels below it
	assign stk_we    = scan_push;
	assign stk_waddr = depth_m1[NW-1:0];
	assign stk_wnode = cur_q;
	assign stk_wcol  = col_q + CW'(1);
	assign stk_re    = scan_pop && (depth_q > CW'(1));
	assign stk_raddr = depth_m2[NW-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			from_q <= NW'(edge_from);
			to_q   <= NW'(edge_to);
			n_q    <= n_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			root_q    <= '0;
			cur_q     <= '0;
			col_q     <= '0;
			depth_q   <= '0;
			visited_q <= '0;
			on_path_q <= '0;
			res_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_ADD && edge_ok) begin
							state_q <= ST_ADD;
						end else if (cmd == CMD_CHECK) begin
							visited_q <= '0;
							on_path_q <= '0;
							depth_q   <= '0;
							root_q    <= '0;
							state_q   <= ST_ROOT;
						end
					end
				end
				ST_ADD: begin
					state_q <= ST_IDLE;
				end
				ST_ROOT: begin
					if (root_end) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (visited_q[root_idx]) begin
						root_q <= root_q + CW'(1);
					end else begin
						cur_q               <= root_idx;
						col_q               <= '0;
						depth_q             <= CW'(1);
						visited_q[root_idx] <= 1'b1;
						on_path_q[root_idx] <= 1'b1;
						state_q             <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (col_end) begin
						on_path_q[cur_q] <= 1'b0;
						depth_q          <= depth_m1;
						if (depth_q == CW'(1)) begin
							root_q  <= root_q + CW'(1);
							state_q <= ST_ROOT;
						end else begin
							state_q <= ST_POP;
						end
					end else if (scan_push) begin
						cur_q              <= col_idx;
						col_q              <= '0;
						depth_q            <= depth_q + CW'(1);
						visited_q[col_idx] <= 1'b1;
						on_path_q[col_idx] <= 1'b1;
					end else if (bit_hit && on_path_q[col_idx]) begin
						res_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_POP: begin
					cur_q   <= stk_rnode;
					col_q   <= stk_rcol;
					state_q <= ST_SCAN;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CW'(MAX_NODES))
		else $error("stack depth beyond node limit");

	a_top_on_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> on_path_q[cur_q])
		else $error("scanned node not on path");

	a_path_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(on_path_q & ~visited_q) == '0)
		else $error("on-path node not marked visited");

	a_walk_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_POP) |-> depth_q != '0)
		else $error("walk active with empty stack");

	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		scan_push |=> state_q == ST_SCAN && depth_q == $past(depth_q) + CW'(1))
		else $error("push did not grow stack");

endmodule

>>> hdl/directed_graph_cycle_detect_core.sv
// Directed graph cycle detector.
// Input channel (in_valid/in_ready) carries one item: cmd, edge_from, edge_to.
//   add edge: sets one adjacency bit, no result.
//   clear:    empties the graph, no result.
//   check:    depth-first walk over nodes below node_count, one result on
//             has_cycle (out_valid/out_ready).
// A check scans adjacency columns in order, tries each unvisited root in turn
// and pops the stack when the node on top has no columns left to scan.
// in_ready stays low while an item is in progress.
// The config channel (cfg_valid/cfg_ready/cfg_data) writes node_count; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. The result sits in an output
// register; new items are taken while it waits. A check that finishes while
// the previous result is still held waits until out_ready frees the register.
// Reset empties the graph, sets node_count to 64 and drops any pending result.
module directed_graph_cycle_detect_core #(
	parameter int MAX_NODES = dgcd_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dgcd_pkg::CMD_W-1:0]        cmd,
	input  logic [dgcd_pkg::NODE_W-1:0]       edge_from,
	input  logic [dgcd_pkg::NODE_W-1:0]       edge_to,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              has_cycle,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dgcd_pkg::NODE_COUNT_W-1:0] cfg_data
);
	import dgcd_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	logic [NODE_COUNT_W-1:0] node_count_q;
	logic                    out_valid_q;
	logic                    has_cycle_q;
	logic                    out_free;
	logic                    fin_valid;
	logic                    fin_res;

	adj_ctl_t             adj_ctl;
	logic [NW-1:0]        adj_addr;
	logic [NW-1:0]        adj_wr_col;
	logic [MAX_NODES-1:0] row;
	logic                 stk_we;
	logic [NW-1:0]        stk_waddr;
	logic [NW-1:0]        stk_wnode;
	logic [CW-1:0]        stk_wcol;
	logic                 stk_re;
	logic [NW-1:0]        stk_raddr;
	logic [NW-1:0]        stk_rnode;
	logic [CW-1:0]        stk_rcol;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign has_cycle = has_cycle_q;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_data;
			end
			if (fin_valid && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && out_free) begin
			has_cycle_q <= fin_res;
		end
	end

	dgcd_adj_mem #(
		.MAX_NODES (MAX_NODES),
		.NW        (NW)
	) u_adj (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (adj_ctl),
		.addr   (adj_addr),
		.wr_col (adj_wr_col),
		.row    (row)
	);

	dgcd_stack #(
		.MAX_NODES (MAX_NODES),
		.NW        (NW),
		.CW        (CW)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wnode (stk_wnode),
		.wcol  (stk_wcol),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rnode (stk_rnode),
		.rcol  (stk_rcol)
	);

	dgcd_ctrl #(
		.MAX_NODES (MAX_NODES),
		.NW        (NW),
		.CW        (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.edge_from  (edge_from),
		.edge_to    (edge_to),
		.node_count (node_count_q),
		.adj_ctl    (adj_ctl),
		.adj_addr   (adj_addr),
		.adj_wr_col (adj_wr_col),
		.row        (row),
		.stk_we     (stk_we),
		.stk_waddr  (stk_waddr),
		.stk_wnode  (stk_wnode),
		.stk_wcol   (stk_wcol),
		.stk_re     (stk_re),
		.stk_raddr  (stk_raddr),
		.stk_rnode  (stk_rnode),
		.stk_rcol   (stk_rcol),
		.out_free   (out_free),
		.fin_valid  (fin_valid),
		.fin_res    (fin_res)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import dgcd_pkg::*;

	localparam int GRAPH_NODES = MAX_NODES_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 700;
	// covers every item being a full-size check under long stalls
	localparam int CYCLE_LIMIT = 20_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] cmd = CMD_ADD;
	logic [NODE_W-1:0] edge_from = '0;
	logic [NODE_W-1:0] edge_to = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic has_cycle;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [NODE_COUNT_W-1:0] cfg_data = '0;

	bit [GRAPH_NODES-1:0] graph_rows [GRAPH_NODES];
	logic [NODE_COUNT_W-1:0] node_count_shadow = NODE_COUNT_RST;
	bit expected_cycle_flags [$];
	bit flag_want;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned graph_items_sent = 0;
	int unsigned sink_left = 0;
	bit no_gaps = 1'b0;

	directed_graph_cycle_detect_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.edge_from (edge_from),
		.edge_to   (edge_to),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.has_cycle (has_cycle),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic bit predict_cycle();
		int unsigned n, depth, top, u, col, v;
		bit seen [GRAPH_NODES];
		bit on_walk [GRAPH_NODES];
		int unsigned walk_node [GRAPH_NODES];
		int unsigned walk_col [GRAPH_NODES];
		bit pushed;
		n = (node_count_shadow > GRAPH_NODES) ? GRAPH_NODES : node_count_shadow;
		seen = '{default: 1'b0};
		on_walk = '{default: 1'b0};
		depth = 0;
		for (int root = 0; root < n; root++) begin
			if (seen[root])
				continue;
			walk_node[0] = root;
			walk_col[0] = 0;
			depth = 1;
			seen[root] = 1'b1;
			on_walk[root] = 1'b1;
			while (depth > 0) begin
				top = depth - 1;
				u = walk_node[top];
				col = walk_col[top];
				pushed = 1'b0;
				while (col < n && !pushed) begin
					v = col;
					col++;
					if (graph_rows[u][v]) begin
						if (!seen[v]) begin
							walk_col[top] = col;
							walk_node[depth] = v;
							walk_col[depth] = 0;
							depth++;
							seen[v] = 1'b1;
							on_walk[v] = 1'b1;
							pushed = 1'b1;
						end else if (on_walk[v]) begin
							return 1'b1;
						end
					end
				end
				if (!pushed) begin
					on_walk[u] = 1'b0;
					depth--;
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic track_graph_item(input logic [CMD_W-1:0] op,
			input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		case (op)
			CMD_ADD: begin
				if (src < GRAPH_NODES && dst < GRAPH_NODES)
					graph_rows[src][dst] = 1'b1;
			end
			CMD_CHECK: begin
				expected_cycle_flags.push_back(predict_cycle());
			end
			CMD_CLEAR: begin
				for (int i = 0; i < GRAPH_NODES; i++)
					graph_rows[i] = '0;
			end
			default: begin
			end
		endcase
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned check_bound();
		int unsigned n;
		n = (node_count_shadow > GRAPH_NODES) ? GRAPH_NODES : node_count_shadow;
		return n * n + 3 * n + 8;
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] op,
			input int unsigned src, input int unsigned dst);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		edge_from <= NODE_W'(src);
		edge_to <= NODE_W'(dst);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_graph_item(op, NODE_W'(src), NODE_W'(dst));
		if (op != CMD_UNUSED)
			graph_items_sent++;
	endtask

	task automatic write_node_count(input int unsigned value);
		in_valid <= 1'b0;
		while (expected_cycle_flags.size() != 0) @(posedge clk);
		// adds and clears give no result and may still be in flight
		repeat (check_bound()) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= NODE_COUNT_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		node_count_shadow = NODE_COUNT_W'(value);
	endtask

	always @(posedge clk) begin
		if (sink_left == 0) begin
			if ($urandom_range(0, 1)) begin
				out_ready <= 1'b1;
				sink_left = $urandom_range(1, 40);
			end else begin
				out_ready <= 1'b0;
				sink_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
			end
		end else begin
			sink_left = sink_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_cycle_flags.size() == 0) begin
				report_mismatch($sformatf("has_cycle %b with no check pending", has_cycle));
			end else begin
				flag_want = expected_cycle_flags.pop_front();
				if (has_cycle !== flag_want)
					report_mismatch($sformatf("has_cycle %b, expected %b", has_cycle, flag_want));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic test_empty_graph();
		send_item(CMD_CHECK, 0, 0);
	endtask

	task automatic test_self_loop();
		send_item(CMD_ADD, 63, 63);
		send_item(CMD_CHECK, 63, 63);
		send_item(CMD_CLEAR, 63, 63);
		send_item(CMD_CHECK, 0, 0);
	endtask

	task automatic test_unused_cmd();
		send_item(CMD_UNUSED, 63, 63);
		send_item(CMD_UNUSED, 0, 0);
		send_item(CMD_CHECK, 21, 42);
	endtask

	task automatic test_long_cycle();
		send_item(CMD_ADD, 0, 21);
		send_item(CMD_ADD, 21, 42);
		send_item(CMD_ADD, 42, 63);
		send_item(CMD_ADD, 63, 0);
		send_item(CMD_CHECK, 42, 21);
		send_item(CMD_CLEAR, 0, 0);
	endtask

	task automatic test_node_limit();
		write_node_count(3);
		send_item(CMD_ADD, 2, 5);
		send_item(CMD_ADD, 5, 2);
		send_item(CMD_CHECK, 0, 0);
		write_node_count(6);
		send_item(CMD_CHECK, 0, 0);
		send_item(CMD_CLEAR, 0, 0);
	endtask

	task automatic test_zero_count();
		write_node_count(0);
		send_item(CMD_ADD, 0, 0);
		send_item(CMD_CHECK, 0, 0);
		write_node_count(1);
		send_item(CMD_CHECK, 0, 0);
		send_item(CMD_CLEAR, 0, 0);
	endtask

	task automatic test_count_saturation();
		write_node_count(127);
		send_item(CMD_ADD, 63, 63);
		send_item(CMD_CHECK, 0, 0);
		send_item(CMD_CLEAR, 0, 0);
	endtask

	task automatic test_random_graphs();
		int unsigned pick, n_eff, span, rounds, edges, style, len, a, b;
		int unsigned ring [6];
		int unsigned count;
		while (graph_items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				count = $urandom_range(1, 8);
			else if (pick < 85)
				count = $urandom_range(9, 20);
			else if (pick < 91)
				count = $urandom_range(21, 63);
			else if (pick < 94)
				count = GRAPH_NODES;
			else if (pick < 97)
				count = $urandom_range(65, 127);
			else
				count = 0;
			n_eff = (count > GRAPH_NODES) ? GRAPH_NODES : count;
			span = (n_eff == 0) ? 8 : n_eff;
			write_node_count(count);
			no_gaps = ($urandom_range(0, 3) == 0);
			rounds = (n_eff > 20) ? $urandom_range(1, 2) : $urandom_range(1, 4);
			repeat (rounds) begin
				if ($urandom_range(0, 4) != 0)
					send_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
				style = $urandom_range(0, 2);
				// style 0 random edges, 1 forward-only edges, 2 planted ring plus random edges
				if (style == 2) begin
					len = $urandom_range(1, (span < 6) ? span : 6);
					for (int i = 0; i < len; i++)
						ring[i] = $urandom_range(0, span - 1);
					for (int i = 0; i < len; i++)
						send_item(CMD_ADD, ring[i], ring[(i + 1) % len]);
				end
				edges = $urandom_range(0, (span < 6) ? 2 * span : 12);
				repeat (edges) begin
					a = $urandom_range(0, span - 1);
					b = $urandom_range(0, span - 1);
					if ($urandom_range(0, 11) == 0) begin
						if ($urandom_range(0, 1))
							send_item(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
						else
							send_item(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
					end else if (style != 1) begin
						send_item(CMD_ADD, a, b);
					end else if (a != b) begin
						send_item(CMD_ADD, (a < b) ? a : b, (a < b) ? b : a);
					end
				end
				send_item(CMD_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
				if ($urandom_range(0, 5) == 0)
					send_item(CMD_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < GRAPH_NODES; i++)
			graph_rows[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_graph();
		test_self_loop();
		test_unused_cmd();
		test_long_cycle();
		test_node_limit();
		test_zero_count();
		test_count_saturation();
		test_random_graphs();

		in_valid <= 1'b0;
		while (expected_cycle_flags.size() != 0) @(posedge clk);
		repeat (check_bound()) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
